FILE: rtl/pec_pkg.sv
package pec_pkg;

	// default sizes of the datapath
	localparam int PROGRESS_FRAC_BITS_DEF = 16;
	localparam int VALUE_BITS_DEF         = 32;
	localparam int BLEND_FRAC_BITS_DEF    = 14;

	// fixed register widths
	localparam int BLEND_W    = 16;
	localparam int DEGREE_W   = 3;
	localparam int DIR_W      = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	// number of power multiplier stages (degree 5 needs four products)
	localparam int POW_STEPS = 4;

	localparam logic [DEGREE_W-1:0] DEGREE_MIN   = 3'd1;
	localparam logic [DEGREE_W-1:0] DEGREE_MAX   = 3'd5;
	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd1;

	// easing direction codes
	typedef enum logic [DIR_W-1:0] {
		DIR_IN    = 2'd0,
		DIR_OUT   = 2'd1,
		DIR_INOUT = 2'd2
	} dir_t;

	// register index, taken from paddr word bits
	typedef enum logic [1:0] {
		REG_DEGREE    = 2'd0,
		REG_DIRECTION = 2'd1,
		REG_BLEND     = 2'd2
	} reg_idx_t;

	// per item control that travels with the data
	typedef struct packed {
		logic                out_half;
		logic                split;
		logic [DEGREE_W-1:0] degree;
	} item_ctl_t;

endpackage

FILE: rtl/pec_front.sv
module pec_front #(
	parameter int PROGRESS_FRAC_BITS = pec_pkg::PROGRESS_FRAC_BITS_DEF,
	parameter int VALUE_BITS         = pec_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PROGRESS_FRAC_BITS:0]         progress,
	input  logic signed [VALUE_BITS-1:0]        start_value,
	input  logic signed [VALUE_BITS-1:0]        change_amount,
	input  logic [pec_pkg::DEGREE_W-1:0]        degree_cfg,
	input  logic [pec_pkg::DIR_W-1:0]           direction_cfg,
	input  logic signed [pec_pkg::BLEND_W-1:0]  blend_cfg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [PROGRESS_FRAC_BITS:0]         x_out,
	output pec_pkg::item_ctl_t                  ctl_out,
	output logic signed [pec_pkg::BLEND_W-1:0]  slope_out,
	output logic signed [VALUE_BITS-1:0]        start_out,
	output logic signed [VALUE_BITS-1:0]        delta_out
);
	import pec_pkg::*;

	localparam int P = PROGRESS_FRAC_BITS;
	localparam logic [P:0] ONE  = {1'b1, {P{1'b0}}};
	localparam logic [P:0] HALF = {2'b01, {(P-1){1'b0}}};

	logic [P:0]          f_clamp;
	logic [P+1:0]        f_dbl;
	logic [P+1:0]        x_split;
	logic [P:0]          x_next;
	logic [DEGREE_W-1:0] deg_clamp;
	logic                out_half_next;
	logic                split_next;
	logic                valid_s1;
	logic [P:0]          x_s1;
	item_ctl_t           ctl_s1;
	logic signed [BLEND_W-1:0]    slope_s1;
	logic signed [VALUE_BITS-1:0] start_s1;
	logic signed [VALUE_BITS-1:0] delta_s1;

	// clamp progress and pick the curve argument
	always_comb begin
		f_clamp = (progress > ONE) ? ONE : progress;
		f_dbl   = {f_clamp, 1'b0};
		x_split = '0;
		// direction three behaves as in-out
		split_next = direction_cfg >= DIR_INOUT;
		if (split_next) begin
			out_half_next = f_clamp >= HALF;
			x_split       = out_half_next ? ({ONE, 1'b0} - f_dbl) : f_dbl;
			x_next        = x_split[P:0];
		end else begin
			out_half_next = direction_cfg == DIR_OUT;
			x_next        = out_half_next ? (ONE - f_clamp) : f_clamp;
		end
		if (degree_cfg < DEGREE_MIN) begin
			deg_clamp = DEGREE_MIN;
		end else if (degree_cfg > DEGREE_MAX) begin
			deg_clamp = DEGREE_MAX;
		end else begin
			deg_clamp = degree_cfg;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1            <= x_next;
			ctl_s1.out_half <= out_half_next;
			ctl_s1.split    <= split_next;
			ctl_s1.degree   <= deg_clamp;
			slope_s1        <= blend_cfg;
			start_s1        <= start_value;
			delta_s1        <= change_amount;
		end
	end

	assign out_valid = valid_s1;
	assign x_out     = x_s1;
	assign ctl_out   = ctl_s1;
	assign slope_out = slope_s1;
	assign start_out = start_s1;
	assign delta_out = delta_s1;

endmodule

FILE: rtl/pec_pow_step.sv
module pec_pow_step #(
	parameter int PROGRESS_FRAC_BITS = pec_pkg::PROGRESS_FRAC_BITS_DEF,
	parameter int VALUE_BITS         = pec_pkg::VALUE_BITS_DEF,
	parameter int STEP               = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PROGRESS_FRAC_BITS:0]         p_in,
	input  logic [PROGRESS_FRAC_BITS:0]         x_in,
	input  pec_pkg::item_ctl_t                  ctl_in,
	input  logic signed [pec_pkg::BLEND_W-1:0]  slope_in,
	input  logic signed [VALUE_BITS-1:0]        start_in,
	input  logic signed [VALUE_BITS-1:0]        delta_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [PROGRESS_FRAC_BITS:0]         p_out,
	output logic [PROGRESS_FRAC_BITS:0]         x_out,
	output pec_pkg::item_ctl_t                  ctl_out,
	output logic signed [pec_pkg::BLEND_W-1:0]  slope_out,
	output logic signed [VALUE_BITS-1:0]        start_out,
	output logic signed [VALUE_BITS-1:0]        delta_out
);
	import pec_pkg::*;

	localparam int P = PROGRESS_FRAC_BITS;
	localparam logic [2*P+1:0] RND = {{(P+2){1'b0}}, 1'b1, {(P-1){1'b0}}};

	logic [2*P+1:0] prod;
	logic [P:0]     p_next;
	logic           valid_q;
	logic [P:0]     p_q;
	logic [P:0]     x_q;
	item_ctl_t      ctl_q;
	logic signed [BLEND_W-1:0]    slope_q;
	logic signed [VALUE_BITS-1:0] start_q;
	logic signed [VALUE_BITS-1:0] delta_q;

	// one more power of x, rounded half up, only while below the degree
	always_comb begin
		prod   = p_in * x_in + RND;
		p_next = (DEGREE_W'(STEP) < ctl_in.degree) ? prod[2*P:P] : p_in;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_q     <= p_next;
			x_q     <= x_in;
			ctl_q   <= ctl_in;
			slope_q <= slope_in;
			start_q <= start_in;
			delta_q <= delta_in;
		end
	end

	assign out_valid = valid_q;
	assign p_out     = p_q;
	assign x_out     = x_q;
	assign ctl_out   = ctl_q;
	assign slope_out = slope_q;
	assign start_out = start_q;
	assign delta_out = delta_q;

endmodule

FILE: rtl/pec_curve.sv
module pec_curve #(
	parameter int PROGRESS_FRAC_BITS = pec_pkg::PROGRESS_FRAC_BITS_DEF,
	parameter int VALUE_BITS         = pec_pkg::VALUE_BITS_DEF,
	parameter int BLEND_FRAC_BITS    = pec_pkg::BLEND_FRAC_BITS_DEF,
	parameter int WEIGHT_W           = 17,
	parameter int CURVE_W            = 36
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PROGRESS_FRAC_BITS:0]         p_in,
	input  logic [PROGRESS_FRAC_BITS:0]         x_in,
	input  pec_pkg::item_ctl_t                  ctl_in,
	input  logic signed [pec_pkg::BLEND_W-1:0]  slope_in,
	input  logic signed [VALUE_BITS-1:0]        start_in,
	input  logic signed [VALUE_BITS-1:0]        delta_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [CURVE_W-1:0]           c_out,
	output pec_pkg::item_ctl_t                  ctl_out,
	output logic signed [VALUE_BITS-1:0]        start_out,
	output logic signed [VALUE_BITS-1:0]        delta_out
);
	import pec_pkg::*;

	localparam int P   = PROGRESS_FRAC_BITS;
	localparam int B   = BLEND_FRAC_BITS;
	localparam int T1W = WEIGHT_W + P + 2;
	localparam int T2W = BLEND_W + P + 2;
	localparam logic signed [WEIGHT_W-1:0] UNITY =
		{{(WEIGHT_W-B-1){1'b0}}, 1'b1, {B{1'b0}}};

	logic signed [WEIGHT_W-1:0] weight;
	logic signed [T1W-1:0]      t1_next;
	logic signed [T2W-1:0]      t2_next;
	logic                       valid_s6;
	logic                       valid_s7;
	logic                       rdy_s7;
	logic signed [T1W-1:0]      t1_s6;
	logic signed [T2W-1:0]      t2_s6;
	item_ctl_t                  ctl_s6;
	item_ctl_t                  ctl_s7;
	logic signed [VALUE_BITS-1:0] start_s6;
	logic signed [VALUE_BITS-1:0] delta_s6;
	logic signed [VALUE_BITS-1:0] start_s7;
	logic signed [VALUE_BITS-1:0] delta_s7;
	logic signed [CURVE_W-1:0]    c_s7;

	// power term weight (1 - s) and the two blend products
	always_comb begin
		weight  = UNITY - WEIGHT_W'(slope_in);
		t1_next = T1W'(weight) * T1W'($signed({1'b0, p_in}));
		t2_next = T2W'(slope_in) * T2W'($signed({1'b0, x_in}));
	end

	// handshake of the two stages
	assign rdy_s7   = !valid_s7 || out_ready;
	assign in_ready = !valid_s6 || rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s6 <= in_valid;
			end
			if (rdy_s7) begin
				valid_s7 <= valid_s6;
			end
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t1_s6    <= t1_next;
			t2_s6    <= t2_next;
			ctl_s6   <= ctl_in;
			start_s6 <= start_in;
			delta_s6 <= delta_in;
		end
	end

	// blended curve value
	always_ff @(posedge clk) begin
		if (valid_s6 && rdy_s7) begin
			c_s7     <= CURVE_W'(t1_s6) + CURVE_W'(t2_s6);
			ctl_s7   <= ctl_s6;
			start_s7 <= start_s6;
			delta_s7 <= delta_s6;
		end
	end

	assign out_valid = valid_s7;
	assign c_out     = c_s7;
	assign ctl_out   = ctl_s7;
	assign start_out = start_s7;
	assign delta_out = delta_s7;

endmodule

FILE: rtl/pec_scale.sv
module pec_scale #(
	parameter int PROGRESS_FRAC_BITS = pec_pkg::PROGRESS_FRAC_BITS_DEF,
	parameter int VALUE_BITS         = pec_pkg::VALUE_BITS_DEF,
	parameter int BLEND_FRAC_BITS    = pec_pkg::BLEND_FRAC_BITS_DEF,
	parameter int CURVE_W            = 36
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [CURVE_W-1:0]     c_in,
	input  pec_pkg::item_ctl_t            ctl_in,
	input  logic signed [VALUE_BITS-1:0]  start_in,
	input  logic signed [VALUE_BITS-1:0]  delta_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [VALUE_BITS-1:0]         eased_value,
	output logic                          clipped
);
	import pec_pkg::*;

	localparam int V   = VALUE_BITS;
	localparam int CL  = CURVE_W / 2;
	localparam int CH  = CURVE_W - CL;
	localparam int PLW = V + CL + 1;
	localparam int PHW = V + CH;
	localparam int PW  = V + CURVE_W;
	localparam int SH  = BLEND_FRAC_BITS + PROGRESS_FRAC_BITS;
	localparam int NW  = V + CURVE_W + 2;
	localparam logic signed [NW-1:0] RND_ONE = {{(NW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
	localparam logic signed [NW-1:0] RND_TWO = {{(NW-SH-1){1'b0}}, 1'b1, {SH{1'b0}}};
	localparam logic [V-1:0] MAXV = {1'b0, {(V-1){1'b1}}};
	localparam logic [V-1:0] MINV = {1'b1, {(V-1){1'b0}}};

	logic                   valid_s8;
	logic                   valid_s9;
	logic                   valid_s10;
	logic                   rdy_s9;
	logic                   rdy_s10;
	logic signed [PLW-1:0]  pl_s8;
	logic signed [PHW-1:0]  ph_s8;
	logic signed [V:0]      base_s8;
	item_ctl_t              ctl_s8;
	logic signed [PW-1:0]   prod_s9;
	logic signed [V:0]      base_s9;
	item_ctl_t              ctl_s9;
	logic signed [NW-1:0]   base_sh;
	logic signed [NW-1:0]   prod_ext;
	logic signed [NW-1:0]   num;
	logic signed [NW-1:0]   quot;
	logic                   fits;
	logic [V-1:0]           res_next;
	logic [V-1:0]           eased_s10;
	logic                   clipped_s10;

	// handshake of the three stages
	assign rdy_s10  = !valid_s10 || out_ready;
	assign rdy_s9   = !valid_s9 || rdy_s10;
	assign in_ready = !valid_s8 || rdy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s8 <= in_valid;
			end
			if (rdy_s9) begin
				valid_s9 <= valid_s8;
			end
			if (rdy_s10) begin
				valid_s10 <= valid_s9;
			end
		end
	end

	// delta times curve as two partial products, base value of the half
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pl_s8   <= PLW'(delta_in) * PLW'($signed({1'b0, c_in[CL-1:0]}));
			ph_s8   <= PHW'(delta_in) * PHW'($signed(c_in[CURVE_W-1:CL]));
			base_s8 <= (V+1)'(start_in) + (ctl_in.out_half ? (V+1)'(delta_in) : '0);
			ctl_s8  <= ctl_in;
		end
	end

	// join partial products
	always_ff @(posedge clk) begin
		if (valid_s8 && rdy_s9) begin
			prod_s9 <= (PW'(ph_s8) <<< CL) + PW'(pl_s8);
			base_s9 <= base_s8;
			ctl_s9  <= ctl_s8;
		end
	end

	// exact sum, round half up, saturate
	always_comb begin
		base_sh  = ctl_s9.split ? ((NW'(base_s9) <<< (SH + 1)) | RND_TWO)
		                        : ((NW'(base_s9) <<< SH) | RND_ONE);
		prod_ext = NW'(prod_s9);
		num      = ctl_s9.out_half ? (base_sh - prod_ext) : (base_sh + prod_ext);
		quot     = ctl_s9.split ? (num >>> (SH + 1)) : (num >>> SH);
		fits     = (quot[NW-1:V-1] == '0) || (quot[NW-1:V-1] == '1);
		if (fits) begin
			res_next = quot[V-1:0];
		end else begin
			res_next = quot[NW-1] ? MINV : MAXV;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (valid_s9 && rdy_s10) begin
			eased_s10   <= res_next;
			clipped_s10 <= !fits;
		end
	end

	assign out_valid   = valid_s10;
	assign eased_value = eased_s10;
	assign clipped     = clipped_s10;

endmodule

FILE: rtl/polynomial_easing_curve_core.sv
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   tdata: progress, start_value, change_amount
// m_        out  m_tvalid/tready   tdata: eased_value; tuser: clipped
// apb       in   psel/penable      curve_degree @0x0, ease_direction @0x4,
//                                  linear_blend @0x8
//
// one request per cycle while the output is not stalled; the pipeline depth is set by
// the four power multiplier stages and the split delta product
// reset clears the stage valid bits and loads the register reset values
// each stage holds while the next one is full, and bubbles close up under a
// stall, so a new request is taken while a result waits on the output
module polynomial_easing_curve_core #(
	parameter int PROGRESS_FRAC_BITS = pec_pkg::PROGRESS_FRAC_BITS_DEF,
	parameter int VALUE_BITS         = pec_pkg::VALUE_BITS_DEF,
	parameter int BLEND_FRAC_BITS    = pec_pkg::BLEND_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// progress, start_value, change_amount from bit 0 up
	input  logic [((PROGRESS_FRAC_BITS+1+2*VALUE_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// eased_value from bit 0 up
	output logic [((VALUE_BITS+7)/8)*8-1:0]        m_tdata,
	// clipped
	output logic                                   m_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pec_pkg::CFG_ADDR_W-1:0]         paddr,
	input  logic [pec_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [pec_pkg::CFG_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import pec_pkg::*;

	localparam int P           = PROGRESS_FRAC_BITS;
	localparam int V           = VALUE_BITS;
	localparam int OUT_TDATA_W = ((V + 7) / 8) * 8;
	localparam int WEIGHT_W    =
		((BLEND_FRAC_BITS > BLEND_W - 1) ? BLEND_FRAC_BITS : BLEND_W - 1) + 2;
	localparam int CURVE_W     = WEIGHT_W + P + 3;

	logic [DEGREE_W-1:0]       degree_q;
	logic [DIR_W-1:0]          direction_q;
	logic signed [BLEND_W-1:0] blend_q;
	logic                      cfg_write;

	logic [P:0]                progress;
	logic signed [V-1:0]       start_value;
	logic signed [V-1:0]       change_amount;

	logic                      pipe_valid [0:POW_STEPS];
	logic                      pipe_ready [0:POW_STEPS];
	logic [P:0]                pipe_p     [0:POW_STEPS];
	logic [P:0]                pipe_x     [0:POW_STEPS];
	item_ctl_t                 pipe_ctl   [0:POW_STEPS];
	logic signed [BLEND_W-1:0] pipe_slope [0:POW_STEPS];
	logic signed [V-1:0]       pipe_start [0:POW_STEPS];
	logic signed [V-1:0]       pipe_delta [0:POW_STEPS];

	logic                      curve_valid;
	logic                      curve_ready;
	logic signed [CURVE_W-1:0] curve_c;
	item_ctl_t                 curve_ctl;
	logic signed [V-1:0]       curve_start;
	logic signed [V-1:0]       curve_delta;
	logic [V-1:0]              eased_value;
	logic                      clipped;

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q    <= DEGREE_RESET;
			direction_q <= DIR_IN;
			blend_q     <= '0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_DEGREE:    degree_q    <= pwdata[DEGREE_W-1:0];
				REG_DIRECTION: direction_q <= pwdata[DIR_W-1:0];
				REG_BLEND:     blend_q     <= $signed(pwdata[BLEND_W-1:0]);
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_DEGREE:    prdata = CFG_DATA_W'(degree_q);
			REG_DIRECTION: prdata = CFG_DATA_W'(direction_q);
			REG_BLEND:     prdata = CFG_DATA_W'($unsigned(blend_q));
			default:       prdata = '0;
		endcase
	end

	// unpack the request
	assign progress      = s_tdata[P:0];
	assign start_value   = $signed(s_tdata[P+V:P+1]);
	assign change_amount = $signed(s_tdata[P+2*V:P+V+1]);

	// clamp and argument selection
	pec_front #(
		.PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
		.VALUE_BITS        (VALUE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.progress     (progress),
		.start_value  (start_value),
		.change_amount(change_amount),
		.degree_cfg   (degree_q),
		.direction_cfg(direction_q),
		.blend_cfg    (blend_q),
		.out_valid    (pipe_valid[0]),
		.out_ready    (pipe_ready[0]),
		.x_out        (pipe_x[0]),
		.ctl_out      (pipe_ctl[0]),
		.slope_out    (pipe_slope[0]),
		.start_out    (pipe_start[0]),
		.delta_out    (pipe_delta[0])
	);

	assign pipe_p[0] = pipe_x[0];

	// power chain, one product per stage
	for (genvar k = 1; k <= POW_STEPS; k++) begin : g_pow
		pec_pow_step #(
			.PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
			.VALUE_BITS        (VALUE_BITS),
			.STEP              (k)
		) u_pow (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (pipe_valid[k-1]),
			.in_ready (pipe_ready[k-1]),
			.p_in     (pipe_p[k-1]),
			.x_in     (pipe_x[k-1]),
			.ctl_in   (pipe_ctl[k-1]),
			.slope_in (pipe_slope[k-1]),
			.start_in (pipe_start[k-1]),
			.delta_in (pipe_delta[k-1]),
			.out_valid(pipe_valid[k]),
			.out_ready(pipe_ready[k]),
			.p_out    (pipe_p[k]),
			.x_out    (pipe_x[k]),
			.ctl_out  (pipe_ctl[k]),
			.slope_out(pipe_slope[k]),
			.start_out(pipe_start[k]),
			.delta_out(pipe_delta[k])
		);
	end

	// blend of power and linear terms
	pec_curve #(
		.PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
		.VALUE_BITS        (VALUE_BITS),
		.BLEND_FRAC_BITS   (BLEND_FRAC_BITS),
		.WEIGHT_W          (WEIGHT_W),
		.CURVE_W           (CURVE_W)
	) u_curve (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pipe_valid[POW_STEPS]),
		.in_ready (pipe_ready[POW_STEPS]),
		.p_in     (pipe_p[POW_STEPS]),
		.x_in     (pipe_x[POW_STEPS]),
		.ctl_in   (pipe_ctl[POW_STEPS]),
		.slope_in (pipe_slope[POW_STEPS]),
		.start_in (pipe_start[POW_STEPS]),
		.delta_in (pipe_delta[POW_STEPS]),
		.out_valid(curve_valid),
		.out_ready(curve_ready),
		.c_out    (curve_c),
		.ctl_out  (curve_ctl),
		.start_out(curve_start),
		.delta_out(curve_delta)
	);

	// scaling, rounding and saturation
	pec_scale #(
		.PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS),
		.VALUE_BITS        (VALUE_BITS),
		.BLEND_FRAC_BITS   (BLEND_FRAC_BITS),
		.CURVE_W           (CURVE_W)
	) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (curve_valid),
		.in_ready   (curve_ready),
		.c_in       (curve_c),
		.ctl_in     (curve_ctl),
		.start_in   (curve_start),
		.delta_in   (curve_delta),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.eased_value(eased_value),
		.clipped    (clipped)
	);

	assign m_tdata = OUT_TDATA_W'(eased_value);
	assign m_tuser = clipped;

endmodule

FILE: rtl/pec_checker.sv
module pec_checker #(
	parameter int VALUE_BITS  = pec_pkg::VALUE_BITS_DEF,
	parameter int OUT_TDATA_W = ((pec_pkg::VALUE_BITS_DEF + 7) / 8) * 8
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [OUT_TDATA_W-1:0]          m_tdata,
	input logic                            m_tuser,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [pec_pkg::CFG_ADDR_W-1:0]  paddr,
	input logic [pec_pkg::CFG_DATA_W-1:0]  pwdata,
	input logic [pec_pkg::CFG_DATA_W-1:0]  prdata
);
	import pec_pkg::*;

	localparam logic [VALUE_BITS-1:0] MAXV = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] MINV = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// saturation lands exactly on a range limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[VALUE_BITS-1:0] == MAXV) || (m_tdata[VALUE_BITS-1:0] == MINV))
		else $error("clipped result is not a range limit");

	// input back-pressure only when the whole pipe is full behind a stall
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input refused with room in the pipe");

	// direction written then read back
	a_dir_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[3:2] == REG_DIRECTION)
		##1 psel && !pwrite && (paddr[3:2] == REG_DIRECTION)
		|-> prdata[DIR_W-1:0] == $past(pwdata[DIR_W-1:0]))
		else $error("direction readback mismatch");

	// input ready stays known after a request is taken
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$isunknown(s_tready))
		else $error("input ready unknown after a request");

endmodule

bind polynomial_easing_curve_core pec_checker #(
	.VALUE_BITS (VALUE_BITS),
	.OUT_TDATA_W(OUT_TDATA_W)
) u_pec_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pec_pkg::*;

	localparam longint UNIT_PROGRESS = 64'd65536;
	localparam int     PHASES        = 14;
	localparam int     PHASE_ITEMS   = 134;
	localparam int     DRAIN_CYCLES  = 14;
	localparam int     HOLD_CYCLES   = 80;
	localparam int     STALL_LIMIT   = 2000;

	typedef struct packed {
		logic [31:0] value;
		logic        clipped;
	} eased_t;

	typedef struct packed {
		logic [2:0]  degree;
		logic [1:0]  direction;
		logic [15:0] blend;
		logic [16:0] progress;
		logic [31:0] start_value;
		logic [31:0] change_amount;
		logic        typed;
		eased_t      result;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic [87:0] s_tdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// settings as the block holds them
	logic [2:0]         cur_degree;
	logic [1:0]         cur_direction;
	logic signed [15:0] cur_blend;

	eased_t  expected_eased[$];
	vector_t directed_vectors[$];
	int      mismatch_count;
	int      quiet_cycles;
	bit      send_gaps;
	bit      stall_enable;
	bit      hold_request;

	polynomial_easing_curve_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// start + change * blended power curve, rounded once, saturated
	function automatic eased_t predict_eased(input logic [16:0] progress,
			input logic signed [31:0] start_value, input logic signed [31:0] change_amount);
		longint             frac;
		longint             arg;
		longint             power;
		longint             weight;
		longint             shape;
		int                 degree;
		int                 shift;
		bit                 mirrored;
		bit                 split;
		logic signed [127:0] acc;
		logic signed [127:0] change_w;
		logic signed [127:0] shape_w;
		eased_t             res;
		frac = progress;
		if (frac > UNIT_PROGRESS)
			frac = UNIT_PROGRESS;
		degree = cur_degree;
		if (degree < 1)
			degree = 1;
		if (degree > 5)
			degree = 5;
		weight = longint'(cur_blend);
		// bit 1 of the direction selects in-out
		split = cur_direction[1];
		if (split) begin
			mirrored = (frac >= UNIT_PROGRESS / 2);
			arg = mirrored ? 2 * UNIT_PROGRESS - 2 * frac : 2 * frac;
		end else begin
			mirrored = (cur_direction == DIR_OUT);
			arg = mirrored ? UNIT_PROGRESS - frac : frac;
		end
		shift = 30 + (split ? 1 : 0);
		// power term, rounded half up after each product
		power = arg;
		for (int i = 1; i < degree; i++)
			power = (power * arg + 64'd32768) >>> 16;
		shape = ((64'sd1 <<< 14) - weight) * power + weight * arg;
		change_w = change_amount;
		shape_w = shape;
		acc = start_value;
		if (mirrored) begin
			acc = acc + change_w;
			acc = (acc <<< shift) - change_w * shape_w;
		end else begin
			acc = (acc <<< shift) + change_w * shape_w;
		end
		acc = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
		// saturate to the signed 32-bit range
		if (acc > 128'sd2147483647) begin
			res.value = 32'h7fff_ffff;
			res.clipped = 1'b1;
		end else if (acc < -128'sd2147483648) begin
			res.value = 32'h8000_0000;
			res.clipped = 1'b1;
		end else begin
			res.value = acc[31:0];
			res.clipped = 1'b0;
		end
		return res;
	endfunction

	// directed vector, typed result used when typed is set
	task automatic add_vector(input logic [2:0] degree, input logic [1:0] direction,
			input logic [15:0] blend, input logic [16:0] progress,
			input logic [31:0] start_value, input logic [31:0] change_amount,
			input logic typed, input logic [31:0] value, input logic clipped);
		vector_t v;
		v.degree = degree;
		v.direction = direction;
		v.blend = blend;
		v.progress = progress;
		v.start_value = start_value;
		v.change_amount = change_amount;
		v.typed = typed;
		v.result.value = value;
		v.result.clipped = clipped;
		directed_vectors.push_back(v);
	endtask

	// register write, setup then access
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEGREE:    cur_degree = data[2:0];
			REG_DIRECTION: cur_direction = data[1:0];
			default:       cur_blend = data[15:0];
		endcase
	endtask

	// registers change only with the pipeline empty
	task automatic apply_setting(input logic [2:0] degree, input logic [1:0] direction,
			input logic [15:0] blend);
		if (degree == cur_degree && direction == cur_direction && blend == cur_blend)
			return;
		s_tvalid <= 1'b0;
		while (expected_eased.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (degree != cur_degree)
			write_reg(REG_DEGREE, {29'd0, degree});
		if (direction != cur_direction)
			write_reg(REG_DIRECTION, {30'd0, direction});
		if (blend != cur_blend)
			write_reg(REG_BLEND, {16'd0, blend});
	endtask

	// offer one request and record its result once taken
	task automatic send_request(input logic [16:0] progress, input logic [31:0] start_value,
			input logic [31:0] change_amount, input logic typed, input eased_t typed_result);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tdata <= {7'd0, change_amount, start_value, progress};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (typed)
			expected_eased.push_back(typed_result);
		else
			expected_eased.push_back(predict_eased(progress, start_value, change_amount));
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 6))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'($urandom_range(0, 2000)) - 32'd1000;
			3:       return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] pick_progress();
		case ($urandom_range(0, 9))
			0:       return 17'd0;
			1:       return 17'd65536;
			2:       return 17'($urandom_range(65537, 131071));
			3:       return 17'd32768;
			4:       return 17'($urandom_range(32760, 32775));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// receiver, with short stalls and one long hold
	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (stall_enable && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		eased_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_eased.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: value %h clipped %b", m_tdata, m_tuser);
			end else begin
				want = expected_eased.pop_front();
				if (m_tdata !== want.value || m_tuser !== want.clipped) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected value %h clipped %b, got value %h clipped %b",
							want.value, want.clipped, m_tdata, m_tuser);
				end
			end
		end
	end

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [2:0]  degree;
		logic [1:0]  direction;
		logic [15:0] blend;
		eased_t      none;
		arst_n = 1'b0;
		s_tdata = '0;
		s_tvalid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_degree = DEGREE_RESET;
		cur_direction = DIR_IN;
		cur_blend = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		send_gaps = 1'b0;
		stall_enable = 1'b0;
		hold_request = 1'b0;
		none = '0;

		// reset defaults: linear ease in
		add_vector(1, DIR_IN, 0, 0, 1234, 5678, 1, 1234, 0);
		add_vector(1, DIR_IN, 0, 65536, 1000, -300, 1, 700, 0);
		// progress above one clamps
		add_vector(1, DIR_IN, 0, 131071, 5, 10, 1, 15, 0);
		add_vector(1, DIR_IN, 0, 65537, -7, 7, 1, 0, 0);
		add_vector(1, DIR_IN, 0, 32768, 0, 100, 1, 50, 0);
		// saturation at both ends
		add_vector(1, DIR_IN, 0, 65536, 32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		add_vector(1, DIR_IN, 0, 65536, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_vector(1, DIR_IN, 0, 0, 32'h8000_0000, 0, 1, 32'h8000_0000, 0);
		// degree zero runs linear, six and seven run quintic
		add_vector(0, DIR_IN, 0, 32768, 0, 1000, 0, 0, 0);
		add_vector(2, DIR_IN, 0, 32768, 0, 1000, 0, 0, 0);
		add_vector(3, DIR_IN, 0, 40000, -50, 100000, 0, 0, 0);
		add_vector(4, DIR_IN, 0, 40000, -50, 100000, 0, 0, 0);
		add_vector(5, DIR_IN, 0, 40000, -50, 100000, 0, 0, 0);
		add_vector(6, DIR_IN, 0, 40000, -50, 100000, 0, 0, 0);
		add_vector(7, DIR_IN, 0, 40000, -50, 100000, 0, 0, 0);
		// ease out, in-out with its midpoint, direction three
		add_vector(2, DIR_OUT, 0, 16384, 10, 2000, 0, 0, 0);
		add_vector(3, DIR_INOUT, 0, 32768, 0, 1000, 0, 0, 0);
		add_vector(3, DIR_INOUT, 0, 32767, 0, 1000, 0, 0, 0);
		add_vector(3, 2'd3, 0, 49152, 0, 1000, 0, 0, 0);
		// blend extremes
		add_vector(3, DIR_IN, 16'h7fff, 40000, -5, 123456, 0, 0, 0);
		add_vector(3, DIR_IN, 16'h8000, 40000, 0, 32'h7fff_ffff, 0, 0, 0);
		add_vector(5, DIR_OUT, 16'h4000, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
		add_vector(2, DIR_INOUT, 16'h8000, 65536, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors
		foreach (directed_vectors[i]) begin
			apply_setting(directed_vectors[i].degree, directed_vectors[i].direction,
				directed_vectors[i].blend);
			send_request(directed_vectors[i].progress, directed_vectors[i].start_value,
				directed_vectors[i].change_amount, directed_vectors[i].typed,
				directed_vectors[i].result);
		end

		// random phases, settings extremes first, calm tail at the end
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       begin degree = 5; direction = DIR_INOUT; blend = 16'h8000; end
				1:       begin degree = 1; direction = DIR_OUT;   blend = 16'h7fff; end
				2:       begin degree = 0; direction = 2'd3;      blend = 16'h4000; end
				3:       begin degree = 7; direction = DIR_IN;    blend = 16'h0000; end
				default: begin
					degree = 3'($urandom_range(0, 7));
					direction = 2'($urandom_range(0, 3));
					blend = 16'($urandom);
				end
			endcase
			apply_setting(degree, direction, blend);
			send_gaps = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
			stall_enable = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
			// long receiver hold so the pipeline fills and stalls the input
			if (phase == 1) begin
				send_gaps = 1'b0;
				hold_request = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_progress(), pick_value(), pick_value(), 1'b0, none);
		end
		s_tvalid <= 1'b0;

		// drain
		while (expected_eased.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_eased.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pec_pkg.sv
rtl/pec_front.sv
rtl/pec_pow_step.sv
rtl/pec_curve.sv
rtl/pec_scale.sv
rtl/polynomial_easing_curve_core.sv
rtl/pec_checker.sv
tb/tb.sv
